### src/bbt_pkg.sv
// shared types and constants of the bounding box build and transform block
package bbt_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int MAT_WIDTH   = 32;
   localparam int REG_WIDTH   = 64;
   localparam int REG_COUNT   = 6;
   localparam int REG_IDX_W   = 3;
   localparam int PROD_WIDTH  = COORD_WIDTH + MAT_WIDTH;
   localparam int TERM_WIDTH  = PROD_WIDTH - 16;
   localparam int SUM_WIDTH   = TERM_WIDTH + 2;

   localparam logic [REG_IDX_W-1:0] REG_ROW0_COLS01 = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_ROW0_COLS23 = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_ROW1_COLS01 = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_ROW1_COLS23 = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_ROW2_COLS01 = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_ROW2_COLS23 = 3'd5;

   localparam logic [REG_WIDTH-1:0] UNIT_HIGH = 64'h0001_0000_0000_0000;
   localparam logic [REG_WIDTH-1:0] UNIT_LOW  = 64'h0000_0000_0001_0000;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   localparam coord_type COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam coord_type COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   typedef struct packed {
      coord_type min_x;
      coord_type min_y;
      coord_type min_z;
      coord_type max_x;
      coord_type max_y;
      coord_type max_z;
   } box_type;

   typedef struct packed {
      box_type local_box;
      box_type world_box;
   } result_type;

   function automatic logic [REG_WIDTH-1:0] reg_reset(input logic [REG_IDX_W-1:0] idx);
      logic [REG_WIDTH-1:0] v;
      v = '0;
      if (idx == REG_ROW0_COLS01) v = UNIT_HIGH;
      if (idx == REG_ROW1_COLS01) v = UNIT_LOW;
      if (idx == REG_ROW2_COLS23) v = UNIT_HIGH;
      return v;
   endfunction

endpackage

### src/bbt_front.sv
// front part: running per-axis min and max over the vertex stream
module bbt_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  bbt_pkg::coord_type  pos_x,
   input  bbt_pkg::coord_type  pos_y,
   input  bbt_pkg::coord_type  pos_z,
   input  logic                first_vertex,
   input  logic                last_vertex,
   output logic                box_push,
   output bbt_pkg::box_type    box_out
);

   bbt_pkg::box_type run_ff, run_in;

   always_comb begin
      run_in = run_ff;
      if (first_vertex) begin
         run_in.min_x = pos_x; run_in.min_y = pos_y; run_in.min_z = pos_z;
         run_in.max_x = pos_x; run_in.max_y = pos_y; run_in.max_z = pos_z;
      end else begin
         if (pos_x < run_ff.min_x) run_in.min_x = pos_x;
         if (pos_y < run_ff.min_y) run_in.min_y = pos_y;
         if (pos_z < run_ff.min_z) run_in.min_z = pos_z;
         if (pos_x > run_ff.max_x) run_in.max_x = pos_x;
         if (pos_y > run_ff.max_y) run_in.max_y = pos_y;
         if (pos_z > run_ff.max_z) run_in.max_z = pos_z;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff.min_x <= bbt_pkg::COORD_MAX;
         run_ff.min_y <= bbt_pkg::COORD_MAX;
         run_ff.min_z <= bbt_pkg::COORD_MAX;
         run_ff.max_x <= bbt_pkg::COORD_MIN;
         run_ff.max_y <= bbt_pkg::COORD_MIN;
         run_ff.max_z <= bbt_pkg::COORD_MIN;
      end else if (accept) begin
         run_ff <= run_in;
      end
   end

   assign box_push = accept & last_vertex;
   assign box_out  = run_in;

endmodule

### src/bbt_box_queue.sv
// two-entry queue of local boxes between front and back
module bbt_box_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  bbt_pkg::box_type  box_in,
   output logic              full,
   input  logic              pop,
   output bbt_pkg::box_type  box_out,
   output logic              empty
);

   bbt_pkg::box_type mem_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] cnt_ff;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= box_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   assign box_out = mem_ff[rd_ptr_ff];
   assign full    = cnt_ff[1];
   assign empty   = (cnt_ff == 2'd0);

endmodule

### src/bbt_xform.sv
// back part: matrix registers, corner transform pipeline and result queue
module bbt_xform (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [bbt_pkg::REG_IDX_W-1:0]     csr_index,
   input  logic [bbt_pkg::REG_WIDTH-1:0]     csr_data,
   input  logic                              box_empty,
   input  bbt_pkg::box_type                  box_in,
   output logic                              box_pop,
   input  logic                              rsp_pop,
   output logic                              rsp_empty,
   output bbt_pkg::result_type               rsp_result
);

   localparam int CW = bbt_pkg::COORD_WIDTH;
   localparam int MW = bbt_pkg::MAT_WIDTH;
   localparam int PW = bbt_pkg::PROD_WIDTH;
   localparam int SW = bbt_pkg::SUM_WIDTH;

   localparam logic signed [SW-1:0] SUM_MAX = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
   localparam logic signed [SW-1:0] SUM_MIN = {{(SW-CW+1){1'b1}}, {(CW-1){1'b0}}};

   logic [bbt_pkg::REG_WIDTH-1:0] regs_ff [bbt_pkg::REG_COUNT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < bbt_pkg::REG_COUNT; i++) begin
            regs_ff[i] <= bbt_pkg::reg_reset(bbt_pkg::REG_IDX_W'(i));
         end
      end else if (csr_wr_en && csr_index <= bbt_pkg::REG_ROW2_COLS23) begin
         regs_ff[csr_index] <= csr_data;
      end
   end

   // sequencer over 8 corners by 3 rows
   logic       busy_ff, iss_ff;
   logic [2:0] k_ff;
   logic [1:0] a_ff;
   bbt_pkg::box_type box_ff;
   logic [1:0] cnt_ff;
   logic       done_ff;
   logic       start, issue_last;

   assign start      = !busy_ff && !box_empty && !cnt_ff[1];
   assign box_pop    = start;
   assign issue_last = (k_ff == 3'd7) && (a_ff == 2'd2);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         iss_ff  <= 1'b0;
         k_ff    <= 3'd0;
         a_ff    <= 2'd0;
      end else begin
         if (start) begin
            busy_ff <= 1'b1;
            iss_ff  <= 1'b1;
            k_ff    <= 3'd0;
            a_ff    <= 2'd0;
         end else if (iss_ff) begin
            if (a_ff == 2'd2) begin
               a_ff <= 2'd0;
               k_ff <= k_ff + 3'd1;
            end else begin
               a_ff <= a_ff + 2'd1;
            end
            if (issue_last) iss_ff <= 1'b0;
         end
         if (done_ff) busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) box_ff <= box_in;
   end

   // stage 1: corner select and three products
   logic [bbt_pkg::REG_WIDTH-1:0] r01, r23;
   bbt_pkg::coord_type cx, cy, cz;

   always_comb begin
      r01 = regs_ff[{a_ff, 1'b0}];
      r23 = regs_ff[{a_ff, 1'b1}];
      cx  = k_ff[0] ? box_ff.max_x : box_ff.min_x;
      cy  = k_ff[1] ? box_ff.max_y : box_ff.min_y;
      cz  = k_ff[2] ? box_ff.max_z : box_ff.min_z;
   end

   logic                 v1_ff, first1_ff, last1_ff;
   logic [1:0]           row1_ff;
   logic signed [PW-1:0] p0_ff, p1_ff, p2_ff;
   logic signed [MW-1:0] t1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= iss_ff;
      end
   end

   always_ff @(posedge clock) begin
      first1_ff <= (k_ff == 3'd0);
      last1_ff  <= issue_last;
      row1_ff   <= a_ff;
      p0_ff     <= cx * $signed(r01[63:32]);
      p1_ff     <= cy * $signed(r01[31:0]);
      p2_ff     <= cz * $signed(r23[63:32]);
      t1_ff     <= $signed(r23[31:0]);
   end

   // stage 2: floored terms summed and saturated
   logic signed [SW-1:0] sum;
   bbt_pkg::coord_type   sat;

   always_comb begin
      sum = SW'($signed(p0_ff[PW-1:16])) + SW'($signed(p1_ff[PW-1:16]))
          + SW'($signed(p2_ff[PW-1:16])) + SW'(t1_ff);
      if (sum > SUM_MAX)      sat = bbt_pkg::COORD_MAX;
      else if (sum < SUM_MIN) sat = bbt_pkg::COORD_MIN;
      else                    sat = sum[CW-1:0];
   end

   logic               v2_ff, first2_ff, last2_ff;
   logic [1:0]         row2_ff;
   bbt_pkg::coord_type w2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      first2_ff <= first1_ff;
      last2_ff  <= last1_ff;
      row2_ff   <= row1_ff;
      w2_ff     <= sat;
   end

   // stage 3: world min and max per row
   bbt_pkg::coord_type wmin_ff [3];
   bbt_pkg::coord_type wmax_ff [3];

   always_ff @(posedge clock) begin
      if (v2_ff) begin
         for (int i = 0; i < 3; i++) begin
            if (row2_ff == 2'(i)) begin
               if (first2_ff || w2_ff < wmin_ff[i]) wmin_ff[i] <= w2_ff;
               if (first2_ff || w2_ff > wmax_ff[i]) wmax_ff[i] <= w2_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= v2_ff & last2_ff;
      end
   end

   // result queue
   bbt_pkg::result_type res, rq_ff [2];
   logic wr_ptr_ff, rd_ptr_ff, pop_ok;

   always_comb begin
      res.local_box       = box_ff;
      res.world_box.min_x = wmin_ff[0];
      res.world_box.min_y = wmin_ff[1];
      res.world_box.min_z = wmin_ff[2];
      res.world_box.max_x = wmax_ff[0];
      res.world_box.max_y = wmax_ff[1];
      res.world_box.max_z = wmax_ff[2];
   end

   assign pop_ok = rsp_pop && (cnt_ff != 2'd0);

   always_ff @(posedge clock) begin
      if (done_ff) rq_ff[wr_ptr_ff] <= res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (done_ff) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop_ok)  rd_ptr_ff <= ~rd_ptr_ff;
         cnt_ff <= cnt_ff + {1'b0, done_ff} - {1'b0, pop_ok};
      end
   end

   assign rsp_empty  = (cnt_ff == 2'd0);
   assign rsp_result = rq_ff[rd_ptr_ff];

endmodule

### src/bounding_box_build_and_transform_top.sv
// top level of the bounding box build and transform block
//
//   channel   ports                         handshake
//   request   req_pos_x/y/z, req_first/last push / full
//   result    rsp_local_*, rsp_world_*      empty / pop
//   config    csr_index, csr_data           csr_wr_en, no wait
//
// one vertex request per cycle while req_full is low; running min and max are
// combinational and registered. a mesh end is transformed over 8 corners, one
// corner row per cycle through three multipliers, then passes the pipeline and result queue.
// two boxes wait in the box queue; full rises when it holds two.
// synchronous reset loads the identity matrix and empties both queues.
module bounding_box_build_and_transform_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  bbt_pkg::coord_type            req_pos_x,
   input  bbt_pkg::coord_type            req_pos_y,
   input  bbt_pkg::coord_type            req_pos_z,
   input  logic                          req_first_vertex,
   input  logic                          req_last_vertex,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output bbt_pkg::coord_type            rsp_local_min_x,
   output bbt_pkg::coord_type            rsp_local_min_y,
   output bbt_pkg::coord_type            rsp_local_min_z,
   output bbt_pkg::coord_type            rsp_local_max_x,
   output bbt_pkg::coord_type            rsp_local_max_y,
   output bbt_pkg::coord_type            rsp_local_max_z,
   output bbt_pkg::coord_type            rsp_world_min_x,
   output bbt_pkg::coord_type            rsp_world_min_y,
   output bbt_pkg::coord_type            rsp_world_min_z,
   output bbt_pkg::coord_type            rsp_world_max_x,
   output bbt_pkg::coord_type            rsp_world_max_y,
   output bbt_pkg::coord_type            rsp_world_max_z,
   input  logic                          csr_wr_en,
   input  logic [bbt_pkg::REG_IDX_W-1:0] csr_index,
   input  logic [bbt_pkg::REG_WIDTH-1:0] csr_data
);

   logic                box_push, box_pop, box_empty, accept;
   bbt_pkg::box_type    box_front, box_back;
   bbt_pkg::result_type result;

   assign accept = req_push & ~req_full;

   bbt_front u_front (
      .clock(clock), .reset(reset), .accept(accept),
      .pos_x(req_pos_x), .pos_y(req_pos_y), .pos_z(req_pos_z),
      .first_vertex(req_first_vertex), .last_vertex(req_last_vertex),
      .box_push(box_push), .box_out(box_front)
   );

   bbt_box_queue u_queue (
      .clock(clock), .reset(reset), .push(box_push), .box_in(box_front),
      .full(req_full), .pop(box_pop), .box_out(box_back), .empty(box_empty)
   );

   bbt_xform u_xform (
      .clock(clock), .reset(reset), .csr_wr_en(csr_wr_en),
      .csr_index(csr_index), .csr_data(csr_data),
      .box_empty(box_empty), .box_in(box_back), .box_pop(box_pop),
      .rsp_pop(rsp_pop), .rsp_empty(rsp_empty), .rsp_result(result)
   );

   assign rsp_local_min_x = result.local_box.min_x;
   assign rsp_local_min_y = result.local_box.min_y;
   assign rsp_local_min_z = result.local_box.min_z;
   assign rsp_local_max_x = result.local_box.max_x;
   assign rsp_local_max_y = result.local_box.max_y;
   assign rsp_local_max_z = result.local_box.max_z;
   assign rsp_world_min_x = result.world_box.min_x;
   assign rsp_world_min_y = result.world_box.min_y;
   assign rsp_world_min_z = result.world_box.min_z;
   assign rsp_world_max_x = result.world_box.max_x;
   assign rsp_world_max_y = result.world_box.max_y;
   assign rsp_world_max_z = result.world_box.max_z;

endmodule

### sim/tb.sv
// self-checking testbench of the bounding box build and transform block
module tb;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   bbt_pkg::coord_type req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic req_first_vertex = 1'b0, req_last_vertex = 1'b0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   bbt_pkg::coord_type rsp_local_min_x, rsp_local_min_y, rsp_local_min_z;
   bbt_pkg::coord_type rsp_local_max_x, rsp_local_max_y, rsp_local_max_z;
   bbt_pkg::coord_type rsp_world_min_x, rsp_world_min_y, rsp_world_min_z;
   bbt_pkg::coord_type rsp_world_max_x, rsp_world_max_y, rsp_world_max_z;
   logic csr_wr_en = 1'b0;
   logic [bbt_pkg::REG_IDX_W-1:0] csr_index = '0;
   logic [bbt_pkg::REG_WIDTH-1:0] csr_data = '0;

   localparam int DRAIN_CYCLES = 40;

   logic [bbt_pkg::REG_WIDTH-1:0] matrix_regs [bbt_pkg::REG_COUNT];
   bbt_pkg::coord_type box_min [3];
   bbt_pkg::coord_type box_max [3];
   bbt_pkg::result_type pending_boxes [$];
   int mismatches = 0;
   bit no_idle = 1'b0;
   int pop_hold = 0;

   bounding_box_build_and_transform_top uut (.*);

   always #5 clock = ~clock;

   function automatic int idle_gap();
      if (no_idle) return 0;
      if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
      return $urandom_range(8, 40);
   endfunction

   // one world axis: floored products, exact sum, one saturation
   function automatic bbt_pkg::coord_type world_axis(int row, bbt_pkg::coord_type cx,
                                                     bbt_pkg::coord_type cy,
                                                     bbt_pkg::coord_type cz);
      logic signed [31:0] m0, m1, m2, t;
      logic signed [63:0] p0, p1, p2, sum;
      m0 = matrix_regs[2*row][63:32];
      m1 = matrix_regs[2*row][31:0];
      m2 = matrix_regs[2*row+1][63:32];
      t  = matrix_regs[2*row+1][31:0];
      p0 = cx * m0;
      p1 = cy * m1;
      p2 = cz * m2;
      sum = (p0 >>> 16) + (p1 >>> 16) + (p2 >>> 16) + t;
      if (sum > 64'(bbt_pkg::COORD_MAX)) return bbt_pkg::COORD_MAX;
      if (sum < 64'(bbt_pkg::COORD_MIN)) return bbt_pkg::COORD_MIN;
      return bbt_pkg::coord_type'(sum);
   endfunction

   task automatic fold_vertex(bbt_pkg::coord_type x, bbt_pkg::coord_type y,
                              bbt_pkg::coord_type z, logic f, logic l);
      bbt_pkg::coord_type v [3];
      bbt_pkg::coord_type w [3];
      bbt_pkg::coord_type wmin [3];
      bbt_pkg::coord_type wmax [3];
      bbt_pkg::coord_type c [3];
      bbt_pkg::result_type r;
      v[0] = x; v[1] = y; v[2] = z;
      for (int a = 0; a < 3; a++) begin
         if (f) begin
            box_min[a] = v[a];
            box_max[a] = v[a];
         end else begin
            if (v[a] < box_min[a]) box_min[a] = v[a];
            if (v[a] > box_max[a]) box_max[a] = v[a];
         end
      end
      if (!l) return;
      for (int k = 0; k < 8; k++) begin
         for (int a = 0; a < 3; a++) c[a] = k[a] ? box_max[a] : box_min[a];
         for (int a = 0; a < 3; a++) begin
            w[a] = world_axis(a, c[0], c[1], c[2]);
            if (k == 0 || w[a] < wmin[a]) wmin[a] = w[a];
            if (k == 0 || w[a] > wmax[a]) wmax[a] = w[a];
         end
      end
      r.local_box = '{box_min[0], box_min[1], box_min[2], box_max[0], box_max[1], box_max[2]};
      r.world_box = '{wmin[0], wmin[1], wmin[2], wmax[0], wmax[1], wmax[2]};
      pending_boxes.push_back(r);
   endtask

   // called at a falling edge, returns at a falling edge
   task automatic send_vertex(bbt_pkg::coord_type x, bbt_pkg::coord_type y,
                              bbt_pkg::coord_type z, logic f, logic l);
      int gap;
      req_pos_x = x; req_pos_y = y; req_pos_z = z;
      req_first_vertex = f; req_last_vertex = l;
      req_push = 1'b1;
      forever begin
         @(posedge clock);
         if (!req_full) break;
      end
      fold_vertex(x, y, z, f, l);
      @(negedge clock);
      gap = idle_gap();
      if (gap > 0) begin
         req_push = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic wait_idle();
      req_push = 1'b0;
      while (pending_boxes.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(logic [bbt_pkg::REG_IDX_W-1:0] idx,
                            logic [bbt_pkg::REG_WIDTH-1:0] data);
      csr_wr_en = 1'b1; csr_index = idx; csr_data = data;
      @(negedge clock);
      csr_wr_en = 1'b0;
      if (idx < bbt_pkg::REG_COUNT) matrix_regs[idx] = data;
   endtask

   task automatic load_matrix(logic [bbt_pkg::REG_WIDTH-1:0] r0, r1, r2, r3, r4, r5);
      write_reg(bbt_pkg::REG_ROW0_COLS01, r0);
      write_reg(bbt_pkg::REG_ROW0_COLS23, r1);
      write_reg(bbt_pkg::REG_ROW1_COLS01, r2);
      write_reg(bbt_pkg::REG_ROW1_COLS23, r3);
      write_reg(bbt_pkg::REG_ROW2_COLS01, r4);
      write_reg(bbt_pkg::REG_ROW2_COLS23, r5);
   endtask

   function automatic bbt_pkg::coord_type random_coord();
      case ($urandom_range(0, 7))
         0: return bbt_pkg::COORD_MAX;
         1: return bbt_pkg::COORD_MIN;
         2: return bbt_pkg::coord_type'($urandom_range(0, 2000)) - 1000;
         3: return bbt_pkg::coord_type'($urandom_range(0, 1 << 22)) - (1 << 21);
         default: return bbt_pkg::coord_type'($urandom);
      endcase
   endfunction

   function automatic logic [bbt_pkg::REG_WIDTH-1:0] random_reg();
      logic [31:0] hi, lo;
      hi = $urandom; lo = $urandom;
      if ($urandom_range(0, 1)) hi = 32'($urandom_range(0, 1 << 18)) - (1 << 17);
      if ($urandom_range(0, 1)) lo = 32'($urandom_range(0, 1 << 18)) - (1 << 17);
      return {hi, lo};
   endfunction

   // result checker and pop driver
   always @(posedge clock) begin
      bbt_pkg::result_type got, want;
      if (!reset && rsp_pop && !rsp_empty) begin
         got.local_box = '{rsp_local_min_x, rsp_local_min_y, rsp_local_min_z,
                           rsp_local_max_x, rsp_local_max_y, rsp_local_max_z};
         got.world_box = '{rsp_world_min_x, rsp_world_min_y, rsp_world_min_z,
                           rsp_world_max_x, rsp_world_max_y, rsp_world_max_z};
         if (pending_boxes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected box %h", got);
         end else begin
            want = pending_boxes.pop_front();
            for (int i = 0; i < 12; i++) begin
               if (got[32*i +: 32] !== want[32*i +: 32]) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("box field %0d (from world max z): expected %h, actual %h",
                              i, want[32*i +: 32], got[32*i +: 32]);
               end
            end
         end
      end
   end

   always @(negedge clock) begin
      if (pop_hold > 0) begin
         rsp_pop <= 1'b0;
         pop_hold <= pop_hold - 1;
      end else begin
         rsp_pop <= 1'b1;
         pop_hold <= $urandom_range(0, 3) == 0 ? idle_gap() : 0;
      end
   end

   task automatic test_reset_state();
      // no first mark after reset still starts the box
      send_vertex(32'sd65536, -32'sd131072, 32'sd7, 1'b0, 1'b1);
      send_vertex(32'sd100, 32'sd200, 32'sd300, 1'b1, 1'b1);
      send_vertex(-32'sd5, 32'sd900, 32'sd1, 1'b0, 1'b0);
      send_vertex(32'sd50, 32'sd0, -32'sd1, 1'b0, 1'b1);
      // box kept after a mesh end, accumulation goes on
      send_vertex(32'sd1000, -32'sd1000, 32'sd0, 1'b0, 1'b1);
      wait_idle();
   endtask

   task automatic test_extremes();
      no_idle = 1'b1;
      send_vertex(bbt_pkg::COORD_MAX, bbt_pkg::COORD_MIN, bbt_pkg::COORD_MAX, 1'b1, 1'b0);
      send_vertex(bbt_pkg::COORD_MIN, bbt_pkg::COORD_MAX, bbt_pkg::COORD_MIN, 1'b0, 1'b1);
      wait_idle();
      load_matrix({32'h7fff_ffff, 32'h8000_0000}, {32'h7fff_ffff, 32'h7fff_ffff},
                  {32'h8000_0000, 32'h8000_0000}, {32'h8000_0000, 32'h8000_0000},
                  {32'hffff_ffff, 32'h0000_0001}, {32'h0001_0000, 32'hffff_ffff});
      send_vertex(bbt_pkg::COORD_MAX, bbt_pkg::COORD_MIN, bbt_pkg::COORD_MAX, 1'b1, 1'b1);
      send_vertex(bbt_pkg::COORD_MIN, bbt_pkg::COORD_MIN, bbt_pkg::COORD_MIN, 1'b1, 1'b0);
      send_vertex(bbt_pkg::COORD_MAX, bbt_pkg::COORD_MAX, bbt_pkg::COORD_MAX, 1'b0, 1'b1);
      send_vertex(-32'sd1, 32'sd1, 32'sd0, 1'b1, 1'b1);
      wait_idle();
      load_matrix('0, '0, '0, '0, '0, '0);
      send_vertex(-32'sd70000, 32'sd3, bbt_pkg::COORD_MAX, 1'b1, 1'b1);
      wait_idle();
      no_idle = 1'b0;
   endtask

   task automatic test_ignored_index();
      load_matrix(bbt_pkg::UNIT_HIGH, '0, bbt_pkg::UNIT_LOW, '0, '0, bbt_pkg::UNIT_HIGH);
      // indexes past the register list
      write_reg(bbt_pkg::REG_IDX_W'(bbt_pkg::REG_COUNT), '1);
      write_reg(bbt_pkg::REG_IDX_W'(bbt_pkg::REG_COUNT + 1), 64'h1234_5678_9abc_def0);
      send_vertex(32'sd65536, 32'sd131072, -32'sd65536, 1'b1, 1'b1);
      wait_idle();
   endtask

   task automatic test_random_meshes(int phases, int items_per_phase);
      int sent, len;
      logic f, l;
      for (int p = 0; p < phases; p++) begin
         load_matrix(random_reg(), random_reg(), random_reg(), random_reg(),
                     random_reg(), random_reg());
         no_idle = (p % 3 == 2);
         sent = 0;
         while (sent < items_per_phase) begin
            if ($urandom_range(0, 9) < 8) begin
               len = $urandom_range(0, 3) == 0 ? $urandom_range(8, 20) : $urandom_range(1, 6);
               for (int v = 0; v < len; v++)
                  send_vertex(random_coord(), random_coord(), random_coord(),
                              v == 0, v == len - 1);
               sent += len;
            end else begin
               // noise: marks anywhere
               f = 1'($urandom_range(0, 1));
               l = 1'($urandom_range(0, 1));
               send_vertex(random_coord(), random_coord(), random_coord(), f, l);
               sent++;
            end
         end
         wait_idle();
      end
      no_idle = 1'b0;
   endtask

   initial begin
      for (int i = 0; i < bbt_pkg::REG_COUNT; i++)
         matrix_regs[i] = bbt_pkg::reg_reset(bbt_pkg::REG_IDX_W'(i));
      for (int a = 0; a < 3; a++) begin
         box_min[a] = bbt_pkg::COORD_MAX;
         box_max[a] = bbt_pkg::COORD_MIN;
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_reset_state();
      test_extremes();
      test_ignored_index();
      test_random_meshes(6, 320);
      if (pending_boxes.size() != 0) mismatches++;
      if (mismatches == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #20000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
